### sv/ils_pkg.sv
`default_nettype none
package ils_pkg;
  localparam int DefCapacity = 256;
  localparam int ValueW = 32;
  localparam int LenW = 9;
  localparam int PosW = 8;

  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_HEAD   = 3'd1;
  localparam logic [2:0] KIND_TAIL   = 3'd2;
  localparam logic [2:0] KIND_AT     = 3'd3;
  localparam logic [2:0] KIND_DELETE = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_READ,
    OP_INS,
    OP_DEL
  } op_t;

  typedef struct packed {
    op_t op;
    logic ld_in;
  } ils_cmd_t;

  typedef struct packed {
    logic walk_done;
  } ils_stat_t;
endpackage
`default_nettype wire

### sv/ils_ram.sv
`default_nettype none
module ils_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/ils_ctrl.sv
`default_nettype none
module ils_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire logic [2:0]       kind,
  input  wire logic             ins_ok,
  input  wire logic             del_ok,
  input  wire logic             rd_ok,
  output ils_pkg::ils_cmd_t     cmd,
  input  wire ils_pkg::ils_stat_t stat
);
  import ils_pkg::*;
  typedef enum logic [1:0] {S_IDLE, S_WALK, S_OUT} state_t;
  state_t state_r, state_nxt;
  op_t op_r, op_nxt;
  logic acc;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign acc = in_valid && in_ready;
  assign cmd.op = op_r;
  assign cmd.ld_in = acc;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_WALK;
          op_nxt = OP_NONE;
          unique case (kind) inside
            KIND_READ: if (rd_ok) op_nxt = OP_READ;
            KIND_HEAD, KIND_TAIL, KIND_AT: if (ins_ok) op_nxt = OP_INS;
            KIND_DELETE: if (del_ok) op_nxt = OP_DEL;
            default: op_nxt = OP_NONE;
          endcase
        end
      end
      S_WALK: if (stat.walk_done) begin
        state_nxt = S_OUT;
        op_nxt = OP_NONE;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r <= OP_NONE;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end
endmodule
`default_nettype wire

### sv/ils_dp.sv
`default_nettype none
module ils_dp #(
  parameter int Capacity = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [2:0]                   in_kind,
  input  wire logic [ils_pkg::PosW-1:0]     in_position,
  input  wire logic signed [ils_pkg::ValueW-1:0] in_value,
  input  wire ils_pkg::ils_cmd_t            cmd,
  output ils_pkg::ils_stat_t                stat,
  output logic                              ins_ok,
  output logic                              del_ok,
  output logic                              rd_ok,
  output logic signed [ils_pkg::ValueW-1:0] out_read_value,
  output logic [1:0]                        out_status,
  output logic [ils_pkg::LenW-1:0]          out_length
);
  import ils_pkg::*;
  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);
  localparam int CmpW = (CW > PosW) ? CW : PosW;

  logic [CW-1:0] cnt_r;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic [CW-1:0] tgt;
  logic [CW-1:0] tgt_r, idx_r, end_r;
  logic [ValueW-1:0] val_r, rd_r;
  logic [1:0] st_r;
  logic phase_r;
  logic [AW-1:0] raddr;
  logic [ValueW-1:0] rdata;
  logic we;
  logic [AW-1:0] waddr;
  logic [ValueW-1:0] wdata;
  logic full;

  assign pos_ext = CmpW'(in_position);
  assign cnt_ext = CmpW'(cnt_r);
  assign full = (cnt_r >= CW'(Capacity));
  assign rd_ok = pos_ext < cnt_ext;
  assign del_ok = pos_ext < cnt_ext;
  always_comb begin
    ins_ok = !full;
    if (in_kind == KIND_AT && pos_ext > cnt_ext) ins_ok = 1'b0;
  end
  always_comb begin
    case (in_kind)
      KIND_HEAD: tgt = '0;
      KIND_TAIL: tgt = cnt_r;
      default:   tgt = CW'(pos_ext);
    endcase
  end

  // insert walks idx from count down to target; delete walks target up to count-1
  always_comb begin
    raddr = '0;
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = rdata;
    stat.walk_done = 1'b0;
    unique case (cmd.op)
      OP_NONE: stat.walk_done = 1'b1;
      OP_READ: begin
        raddr = tgt_r[AW-1:0];
        stat.walk_done = phase_r;
      end
      OP_INS: begin
        if (idx_r == tgt_r) begin
          we = 1'b1;
          wdata = val_r;
          stat.walk_done = 1'b1;
        end else begin
          raddr = AW'(idx_r - 1'b1);
          we = phase_r;
        end
      end
      OP_DEL: begin
        if (idx_r == end_r) begin
          stat.walk_done = 1'b1;
        end else begin
          raddr = AW'(idx_r + 1'b1);
          we = phase_r;
        end
      end
      default: stat.walk_done = 1'b1;
    endcase
  end

  ils_ram #(.Width(ValueW), .Depth(Capacity)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      phase_r <= 1'b0;
    end else if (cmd.ld_in) begin
      phase_r <= 1'b0;
      val_r <= in_value;
      tgt_r <= tgt;
      end_r <= cnt_r - 1'b1;
      idx_r <= (in_kind == KIND_DELETE) ? CW'(pos_ext) : cnt_r;
      rd_r <= '0;
      st_r <= ST_DONE;
      case (in_kind) inside
        KIND_READ: if (!rd_ok) begin
          rd_r <= '1;
          st_r <= ST_RANGE;
        end
        KIND_HEAD, KIND_TAIL, KIND_AT: begin
          if (in_kind == KIND_AT && pos_ext > cnt_ext) st_r <= ST_RANGE;
          else if (full) st_r <= ST_FULL;
        end
        KIND_DELETE: if (!del_ok) st_r <= ST_RANGE;
        default: st_r <= ST_DONE;
      endcase
    end else if (!stat.walk_done) begin
      phase_r <= !phase_r;
      if (phase_r && cmd.op == OP_INS) idx_r <= idx_r - 1'b1;
      if (phase_r && cmd.op == OP_DEL) idx_r <= idx_r + 1'b1;
    end else if (cmd.op != OP_NONE) begin
      phase_r <= 1'b0;
      if (cmd.op == OP_READ) rd_r <= rdata;
      if (cmd.op == OP_INS) cnt_r <= cnt_r + 1'b1;
      if (cmd.op == OP_DEL) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign out_read_value = rd_r;
  assign out_status = st_r;
  assign out_length = LenW'(cnt_r);
endmodule
`default_nettype wire

### sv/indexed_list_store_top.sv
// A read does one RAM read; an insert or delete moves each shifted entry with a RAM read then
// a RAM write (an insert then writes the new value); ignored or rejected requests do no walk.
// Throughput: one request at a time; the next can be taken the cycle after the result is taken.
// The time of an insert or delete is set by the shift walk through the element RAM.
// Synchronous active-low reset clears the length and control; RAM contents are not cleared.
`default_nettype none
module indexed_list_store_top #(
  parameter int Capacity = ils_pkg::DefCapacity
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   in_kind,
  input  wire logic [ils_pkg::PosW-1:0]     in_position,
  input  wire logic signed [ils_pkg::ValueW-1:0] in_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [ils_pkg::ValueW-1:0] out_read_value,
  output logic [1:0]                        out_status,
  output logic [ils_pkg::LenW-1:0]          out_length
);
  import ils_pkg::*;
  ils_cmd_t cmd;
  ils_stat_t stat;
  logic ins_ok, del_ok, rd_ok;

  ils_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .kind(in_kind),
    .ins_ok(ins_ok), .del_ok(del_ok), .rd_ok(rd_ok), .cmd(cmd), .stat(stat)
  );

  ils_dp #(.Capacity(Capacity)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_kind(in_kind), .in_position(in_position),
    .in_value(in_value), .cmd(cmd), .stat(stat), .ins_ok(ins_ok), .del_ok(del_ok),
    .rd_ok(rd_ok), .out_read_value(out_read_value), .out_status(out_status),
    .out_length(out_length)
  );
endmodule
`default_nettype wire

### sv/ils_checker.sv
`default_nettype none
module ils_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [8:0] out_length
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_length))
    else $error("result dropped");
  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("double accept");
endmodule

bind indexed_list_store_top ils_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_length(out_length)
);
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ils_pkg::*;

  typedef struct {
    logic signed [ValueW-1:0] read_value;
    logic [1:0]               status;
    logic [LenW-1:0]          length;
  } list_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [2:0]               in_kind;
  logic [PosW-1:0]          in_position;
  logic signed [ValueW-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [ValueW-1:0] out_read_value;
  logic [1:0]               out_status;
  logic [LenW-1:0]          out_length;

  logic signed [ValueW-1:0] model_cells [DefCapacity];
  int                       model_len;
  list_result_t             pending_results [$];
  int                       fail_count;
  bit                       idle_en;
  int                       hold_left;
  int                       stall_left;

  indexed_list_store_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic list_result_t apply_request(logic [2:0] kind, int pos,
                                                 logic signed [ValueW-1:0] val);
    list_result_t r;
    int           at;
    r.read_value = '0;
    r.status = ST_DONE;
    at = -1;
    case (kind)
      KIND_READ: begin
        if (pos < model_len) begin
          r.read_value = model_cells[pos];
        end else begin
          r.read_value = -1;
          r.status = ST_RANGE;
        end
      end
      KIND_HEAD: at = 0;
      KIND_TAIL: at = model_len;
      KIND_AT: begin
        if (pos > model_len) r.status = ST_RANGE;
        else at = pos;
      end
      KIND_DELETE: begin
        if (pos < model_len) begin
          for (int i = pos; i + 1 < model_len; i++) model_cells[i] = model_cells[i + 1];
          model_len--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    if (at >= 0) begin
      if (model_len >= DefCapacity) begin
        r.status = ST_FULL;
      end else begin
        for (int i = model_len; i > at; i--) model_cells[i] = model_cells[i - 1];
        model_cells[at] = val;
        model_len++;
      end
    end
    r.length = model_len[LenW-1:0];
    return r;
  endfunction

  task automatic send_request(logic [2:0] kind, int pos, logic signed [ValueW-1:0] val);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_position <= pos[PosW-1:0];
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_request(kind, pos, val));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: read_value %0d status %0d length %0d",
                   $time, out_read_value, out_status, out_length);
          fail_count++;
        end else begin
          list_result_t e;
          e = pending_results.pop_front();
          if (out_read_value !== e.read_value) begin
            $display("%0t read_value mismatch: expected %0d actual %0d",
                     $time, e.read_value, out_read_value);
            fail_count++;
          end
          if (out_status !== e.status) begin
            $display("%0t status mismatch: expected %0d actual %0d",
                     $time, e.status, out_status);
            fail_count++;
          end
          if (out_length !== e.length) begin
            $display("%0t length mismatch: expected %0d actual %0d",
                     $time, e.length, out_length);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_request(KIND_READ, 0, 0);
    send_request(KIND_READ, 255, 0);
    send_request(KIND_DELETE, 0, 0);
    send_request(KIND_AT, 1, 5);
    send_request(KIND_AT, 0, 32'sh7fffffff);
    send_request(KIND_HEAD, 0, 32'sh80000000);
    send_request(KIND_TAIL, 255, -1);
    send_request(KIND_AT, 3, 0);
    send_request(KIND_AT, 2, 32'sh55555555);
    send_request(KIND_READ, 0, 0);
    send_request(KIND_READ, 1, 0);
    send_request(KIND_READ, 4, 0);
    send_request(KIND_READ, 5, 0);
    send_request(KIND_DELETE, 5, 0);
    send_request(KIND_DELETE, 2, 0);
    send_request(KIND_READ, 2, 0);
    send_request(3'd5, 0, 123);
    send_request(3'd6, 255, -1);
    send_request(3'd7, 1, 7);
    send_request(KIND_DELETE, 0, 0);
    send_request(KIND_READ, 0, 0);
  endtask

  task automatic test_full_store();
    while (model_len < DefCapacity) send_request(KIND_TAIL, 0, $urandom());
    send_request(KIND_HEAD, 0, $urandom());
    send_request(KIND_TAIL, 0, $urandom());
    send_request(KIND_AT, 255, $urandom());
    send_request(KIND_AT, 0, $urandom());
    send_request(KIND_READ, 255, 0);
    send_request(KIND_READ, 128, 0);
    send_request(KIND_DELETE, 255, 0);
    send_request(KIND_AT, 255, $urandom());
    send_request(KIND_AT, 255, $urandom());
    send_request(KIND_READ, 255, 0);
    for (int i = 0; i < 40; i++) send_request(KIND_DELETE, $urandom_range(0, 255), 0);
    while (model_len > 8) send_request(KIND_DELETE, model_len - 1, 0);
  endtask

  task automatic send_random(int count);
    int pick;
    int pos;
    logic [2:0] kind;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      pos  = $urandom_range(0, 255);
      if (pick < 10) begin
        kind = 3'($urandom_range(0, 7));
      end else if (pick < 30) begin
        kind = KIND_READ;
        if (model_len > 0) pos = $urandom_range(0, model_len - 1);
      end else if (pick < (model_len > 180 ? 45 : 70)) begin
        kind = 3'($urandom_range(KIND_HEAD, KIND_AT));
        if (kind == KIND_AT) pos = $urandom_range(0, model_len > 255 ? 255 : model_len);
      end else begin
        kind = KIND_DELETE;
        if (model_len > 0) pos = $urandom_range(0, model_len - 1);
      end
      send_request(kind, pos, $urandom());
    end
  endtask

  task automatic test_random();
    send_random(600);
  endtask

  task automatic test_backpressure();
    hold_left = 1500;
    send_random(6);
    wait_drained();
    send_random(10);
    wait_drained();
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    send_random(100);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_kind     <= KIND_READ;
    in_position <= '0;
    in_value    <= '0;
    fail_count  = 0;
    idle_en     = 1'b1;
    hold_left   = 0;
    model_len   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_store();
    test_random();
    test_backpressure();
    test_no_idle();
    wait_drained();
    repeat (600) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_top NOT OK");
    $finish;
  end
endmodule
